FILE: rtl/core/fgbr_pkg.sv
// Shared types, constants and the 5x7 font table of the glyph block renderer.
`default_nettype none

package fgbr_pkg;

   // Screen geometry.
   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;

   // Field widths of the ports.
   localparam int POS_WIDTH   = 12;
   localparam int CODE_WIDTH  = 8;
   localparam int COLOR_WIDTH = 24;
   localparam int OUT_X_WIDTH = 9;
   localparam int OUT_Y_WIDTH = 8;

   localparam logic [COLOR_WIDTH-1:0] COLOR_RESET = 24'hFFFFFF;

   // Character set and glyph shape.
   localparam int FIRST_CODE        = 32;
   localparam int LAST_CODE         = 125;
   localparam int NEWLINE_CODE      = 10;
   localparam int GLYPH_COLS        = 5;
   localparam int GLYPH_ROWS        = 7;
   localparam int GLYPH_BYTE_WIDTH  = 8;
   localparam int GLYPH_COUNT       = LAST_CODE - FIRST_CODE + 1;
   localparam int GLYPH_INDEX_WIDTH = $clog2(GLYPH_COUNT);
   localparam int COL_WIDTH         = $clog2(GLYPH_COLS);
   localparam int ROW_WIDTH         = $clog2(GLYPH_ROWS);

   // Internal coordinate widths, wide enough for 0 .. size-1.
   localparam int X_WIDTH = $clog2(SCREEN_WIDTH);
   localparam int Y_WIDTH = $clog2(SCREEN_HEIGHT);

   // The signed position is biased by a multiple of the screen size so that
   // the modulo can be taken on a non-negative value.
   localparam int POS_SPAN      = 1 << (POS_WIDTH - 1);
   localparam int POS_OFFSET_X  = SCREEN_WIDTH * ((POS_SPAN + SCREEN_WIDTH - 1) / SCREEN_WIDTH);
   localparam int POS_OFFSET_Y  = SCREEN_HEIGHT *
                                  ((POS_SPAN + SCREEN_HEIGHT - 1) / SCREEN_HEIGHT);
   localparam int BIASED_WIDTH  = POS_WIDTH + 1;

   // Reciprocal multiply for the quotient; the shift keeps it exact for
   // every biased value and every screen size up to 1024.
   localparam int RECIP_SHIFT   = 24;
   localparam int RECIP_X       = (1 << RECIP_SHIFT) / SCREEN_WIDTH + 1;
   localparam int RECIP_Y       = (1 << RECIP_SHIFT) / SCREEN_HEIGHT + 1;
   localparam int PRODUCT_WIDTH = BIASED_WIDTH + RECIP_SHIFT;

   // Decoupling queue between front and back.
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic signed [POS_WIDTH-1:0] pos_x;
      logic signed [POS_WIDTH-1:0] pos_y;
      logic [CODE_WIDTH-1:0]       char_code;
   } req_type;

   typedef struct packed {
      logic [OUT_X_WIDTH-1:0] left_x;
      logic [OUT_X_WIDTH-1:0] right_x;
      logic [OUT_Y_WIDTH-1:0] top_y;
      logic [OUT_Y_WIDTH-1:0] bottom_y;
      logic [COLOR_WIDTH-1:0] pixel_color;
      logic                   last_block;
   } rsp_type;

   // One font entry: column bytes, column 0 first.
   typedef logic [0:GLYPH_COLS-1][GLYPH_BYTE_WIDTH-1:0] glyph_type;

   // Lit cells of one glyph, indexed by column then row.
   typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] cell_mask_type;

   typedef struct packed {
      logic [X_WIDTH-1:0] x0;
      logic [Y_WIDTH-1:0] y0;
      cell_mask_type      cells;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Font table, indexed by character code minus the first printable code.
   function automatic glyph_type glyph_lookup(input logic [GLYPH_INDEX_WIDTH-1:0] index);
      glyph_type glyph;
      unique case (index)
         7'd0:  glyph = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
         7'd1:  glyph = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
         7'd2:  glyph = {8'h00, 8'h07, 8'h00, 8'h07, 8'h00};
         7'd3:  glyph = {8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14};
         7'd4:  glyph = {8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12};
         7'd5:  glyph = {8'h23, 8'h13, 8'h08, 8'h64, 8'h62};
         7'd6:  glyph = {8'h36, 8'h49, 8'h55, 8'h22, 8'h50};
         7'd7:  glyph = {8'h00, 8'h05, 8'h03, 8'h00, 8'h00};
         7'd8:  glyph = {8'h00, 8'h1C, 8'h22, 8'h41, 8'h00};
         7'd9:  glyph = {8'h00, 8'h41, 8'h22, 8'h1C, 8'h00};
         7'd10: glyph = {8'h08, 8'h2A, 8'h1C, 8'h2A, 8'h08};
         7'd11: glyph = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
         7'd12: glyph = {8'h00, 8'h50, 8'h30, 8'h00, 8'h00};
         7'd13: glyph = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
         7'd14: glyph = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
         7'd15: glyph = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
         7'd16: glyph = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
         7'd17: glyph = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
         7'd18: glyph = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
         7'd19: glyph = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
         7'd20: glyph = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
         7'd21: glyph = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
         7'd22: glyph = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
         7'd23: glyph = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
         7'd24: glyph = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         7'd25: glyph = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
         7'd26: glyph = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
         7'd27: glyph = {8'h00, 8'h56, 8'h36, 8'h00, 8'h00};
         7'd28: glyph = {8'h00, 8'h08, 8'h14, 8'h22, 8'h41};
         7'd29: glyph = {8'h14, 8'h14, 8'h14, 8'h14, 8'h14};
         7'd30: glyph = {8'h41, 8'h22, 8'h14, 8'h08, 8'h00};
         7'd31: glyph = {8'h02, 8'h01, 8'h51, 8'h09, 8'h06};
         7'd32: glyph = {8'h32, 8'h49, 8'h79, 8'h41, 8'h3E};
         7'd33: glyph = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
         7'd34: glyph = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
         7'd35: glyph = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
         7'd36: glyph = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
         7'd37: glyph = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
         7'd38: glyph = {8'h7F, 8'h09, 8'h09, 8'h01, 8'h01};
         7'd39: glyph = {8'h3E, 8'h41, 8'h41, 8'h51, 8'h32};
         7'd40: glyph = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
         7'd41: glyph = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
         7'd42: glyph = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
         7'd43: glyph = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
         7'd44: glyph = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
         7'd45: glyph = {8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F};
         7'd46: glyph = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
         7'd47: glyph = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
         7'd48: glyph = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
         7'd49: glyph = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
         7'd50: glyph = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
         7'd51: glyph = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
         7'd52: glyph = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
         7'd53: glyph = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
         7'd54: glyph = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
         7'd55: glyph = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
         7'd56: glyph = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
         7'd57: glyph = {8'h03, 8'h04, 8'h78, 8'h04, 8'h03};
         7'd58: glyph = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
         7'd59: glyph = {8'h00, 8'h00, 8'h7F, 8'h41, 8'h41};
         7'd60: glyph = {8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
         7'd61: glyph = {8'h41, 8'h41, 8'h7F, 8'h00, 8'h00};
         7'd62: glyph = {8'h04, 8'h02, 8'h01, 8'h02, 8'h04};
         7'd63: glyph = {8'h40, 8'h40, 8'h40, 8'h40, 8'h40};
         7'd64: glyph = {8'h00, 8'h01, 8'h02, 8'h04, 8'h00};
         7'd65: glyph = {8'h20, 8'h54, 8'h54, 8'h54, 8'h78};
         7'd66: glyph = {8'h7F, 8'h48, 8'h44, 8'h44, 8'h38};
         7'd67: glyph = {8'h38, 8'h44, 8'h44, 8'h44, 8'h20};
         7'd68: glyph = {8'h38, 8'h44, 8'h44, 8'h48, 8'h7F};
         7'd69: glyph = {8'h38, 8'h54, 8'h54, 8'h54, 8'h18};
         7'd70: glyph = {8'h08, 8'h7E, 8'h09, 8'h01, 8'h02};
         7'd71: glyph = {8'h08, 8'h14, 8'h54, 8'h54, 8'h3C};
         7'd72: glyph = {8'h7F, 8'h08, 8'h04, 8'h04, 8'h78};
         7'd73: glyph = {8'h00, 8'h44, 8'h7D, 8'h40, 8'h00};
         7'd74: glyph = {8'h20, 8'h40, 8'h44, 8'h3D, 8'h00};
         7'd75: glyph = {8'h00, 8'h7F, 8'h10, 8'h28, 8'h44};
         7'd76: glyph = {8'h00, 8'h41, 8'h7F, 8'h40, 8'h00};
         7'd77: glyph = {8'h7C, 8'h04, 8'h18, 8'h04, 8'h78};
         7'd78: glyph = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h78};
         7'd79: glyph = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
         7'd80: glyph = {8'h7C, 8'h14, 8'h14, 8'h14, 8'h08};
         7'd81: glyph = {8'h08, 8'h14, 8'h14, 8'h18, 8'h7C};
         7'd82: glyph = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h08};
         7'd83: glyph = {8'h48, 8'h54, 8'h54, 8'h54, 8'h20};
         7'd84: glyph = {8'h04, 8'h3F, 8'h44, 8'h40, 8'h20};
         7'd85: glyph = {8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C};
         7'd86: glyph = {8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C};
         7'd87: glyph = {8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C};
         7'd88: glyph = {8'h44, 8'h28, 8'h10, 8'h28, 8'h44};
         7'd89: glyph = {8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C};
         7'd90: glyph = {8'h44, 8'h64, 8'h54, 8'h4C, 8'h44};
         7'd91: glyph = {8'h00, 8'h08, 8'h36, 8'h41, 8'h00};
         7'd92: glyph = {8'h00, 8'h00, 8'h7F, 8'h00, 8'h00};
         7'd93: glyph = {8'h00, 8'h41, 8'h36, 8'h08, 8'h00};
         default: glyph = '0;
      endcase
      return glyph;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/font_glyph_block_renderer.sv
// Top level of the 5x7 font glyph renderer that draws 2x2 pixel blocks.
//
//   Port group   Dir   Word                           Handshake
//   req_*        in    pos_x, pos_y, char_code        req_valid / req_ready
//   rsp_*        out   corners, color, last flag      rsp_valid / rsp_ready
//   csr_*        in    foreground color (24 bit)      csr_valid / csr_ready
//
// A character occupies the block emitter once per lit cell (0 to 35); the single result
// register bounds throughput at one pixel block per cycle when not stalled. The front end
// takes a character every cycle while the queue has room; glyphs with no lit cells (space,
// newline, unprintable codes) skip the emitter. A first block passes the stage-one, queue,
// glyph and output registers. Reset is synchronous, clears all valid flags and the queue
// and sets the color to white. Either side may stall for any length of time.
`default_nettype none

module font_glyph_block_renderer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fgbr_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fgbr_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fgbr_pkg::COLOR_WIDTH-1:0]    csr_data
);
   import fgbr_pkg::*;

   logic                      push;
   logic                      pop;
   queue_entry_type           push_data;
   queue_entry_type           pop_data;
   queue_status_type          q_status;
   logic [COLOR_WIDTH-1:0]    fore_color_ff, fore_color_in;

   // Color register, always ready for a write.
   assign csr_ready     = 1'b1;
   assign fore_color_in = (csr_valid && csr_ready) ? csr_data : fore_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fore_color_ff <= COLOR_RESET;
      end else begin
         fore_color_ff <= fore_color_in;
      end
   end

   fgbr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data),
      .q_status  (q_status)
   );

   fgbr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   fgbr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_data     (pop_data),
      .q_status   (q_status),
      .pop        (pop),
      .fore_color (fore_color_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

FILE: rtl/core/fgbr_front.sv
// Front end: accepts characters, looks up the glyph and wraps the position.
`default_nettype none

module fgbr_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  fgbr_pkg::req_type        req_data,
   output logic                     push,
   output fgbr_pkg::queue_entry_type push_data,
   input  fgbr_pkg::queue_status_type q_status
);
   import fgbr_pkg::*;

   logic                           accept;
   logic                           code_printable;
   logic [GLYPH_INDEX_WIDTH-1:0]   glyph_index;
   glyph_type                      glyph;

   logic                           s1_valid_ff, s1_valid_in;
   logic [BIASED_WIDTH-1:0]        s1_biased_x_ff, s1_biased_x_in;
   logic [BIASED_WIDTH-1:0]        s1_biased_y_ff, s1_biased_y_in;
   logic [PRODUCT_WIDTH-1:0]       s1_prod_x_ff, s1_prod_x_in;
   logic [PRODUCT_WIDTH-1:0]       s1_prod_y_ff, s1_prod_y_in;
   cell_mask_type                  s1_cells_ff, s1_cells_in;

   logic                           s1_has_cells;
   logic                           s1_done;
   logic [BIASED_WIDTH-1:0]        quot_x, quot_y;
   logic [BIASED_WIDTH-1:0]        quot_w, quot_h;
   logic [BIASED_WIDTH-1:0]        rem_x, rem_y;

   // Stage one takes a new word whenever it is empty or hands its word on.
   assign s1_has_cells = |s1_cells_ff;
   assign s1_done      = s1_valid_ff && (!s1_has_cells || !q_status.full);
   assign req_ready    = !s1_valid_ff || s1_done;
   assign accept       = req_valid && req_ready;

   // Newline and every code outside the printable range draw as space.
   assign code_printable = (req_data.char_code != CODE_WIDTH'(NEWLINE_CODE)) &&
                           (req_data.char_code >= CODE_WIDTH'(FIRST_CODE)) &&
                           (req_data.char_code <= CODE_WIDTH'(LAST_CODE));
   assign glyph_index = code_printable ?
                        GLYPH_INDEX_WIDTH'(req_data.char_code - CODE_WIDTH'(FIRST_CODE)) : '0;
   assign glyph = glyph_lookup(glyph_index);

   // Bias the position, start the reciprocal multiply and keep the lit cells.
   always_comb begin
      s1_biased_x_in = BIASED_WIDTH'(req_data.pos_x) + BIASED_WIDTH'(POS_OFFSET_X);
      s1_biased_y_in = BIASED_WIDTH'(req_data.pos_y) + BIASED_WIDTH'(POS_OFFSET_Y);
      s1_prod_x_in   = PRODUCT_WIDTH'(s1_biased_x_in) * PRODUCT_WIDTH'(RECIP_X);
      s1_prod_y_in   = PRODUCT_WIDTH'(s1_biased_y_in) * PRODUCT_WIDTH'(RECIP_Y);
      for (int c = 0; c < GLYPH_COLS; c++) begin
         s1_cells_in[c] = glyph[c][GLYPH_ROWS-1:0];
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_biased_x_ff <= s1_biased_x_in;
         s1_biased_y_ff <= s1_biased_y_in;
         s1_prod_x_ff   <= s1_prod_x_in;
         s1_prod_y_ff   <= s1_prod_y_in;
         s1_cells_ff    <= s1_cells_in;
      end
   end

   // Remainder: biased value minus quotient times screen size.
   assign quot_x = s1_prod_x_ff[RECIP_SHIFT +: BIASED_WIDTH];
   assign quot_y = s1_prod_y_ff[RECIP_SHIFT +: BIASED_WIDTH];
   assign quot_w = quot_x * BIASED_WIDTH'(SCREEN_WIDTH);
   assign quot_h = quot_y * BIASED_WIDTH'(SCREEN_HEIGHT);
   assign rem_x  = s1_biased_x_ff - quot_w;
   assign rem_y  = s1_biased_y_ff - quot_h;

   // Only glyphs with lit cells go on to the back end.
   assign push            = s1_valid_ff && s1_has_cells && !q_status.full;
   assign push_data.x0    = rem_x[X_WIDTH-1:0];
   assign push_data.y0    = rem_y[Y_WIDTH-1:0];
   assign push_data.cells = s1_cells_ff;

endmodule

`default_nettype wire

FILE: rtl/core/fgbr_queue.sv
// Short queue that decouples the glyph front end from the block emitter.
`default_nettype none

module fgbr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  fgbr_pkg::queue_entry_type  push_data,
   input  logic                       pop,
   output fgbr_pkg::queue_entry_type  pop_data,
   output fgbr_pkg::queue_status_type status
);
   import fgbr_pkg::*;

   queue_entry_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]   count_ff, count_in;

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

FILE: rtl/core/fgbr_back.sv
// Back end: walks one glyph's lit cells, a pixel block a cycle unless stalled.
`default_nettype none

module fgbr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  fgbr_pkg::queue_entry_type  q_data,
   input  fgbr_pkg::queue_status_type q_status,
   output logic                       pop,
   input  logic [fgbr_pkg::COLOR_WIDTH-1:0] fore_color,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output fgbr_pkg::rsp_type          rsp_data
);
   import fgbr_pkg::*;

   logic                     cur_valid_ff, cur_valid_in;
   logic [X_WIDTH-1:0]       cur_x_ff;
   logic [Y_WIDTH-1:0]       cur_y_ff;
   cell_mask_type            cur_cells_ff, cur_cells_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic [COL_WIDTH-1:0]     col_sel;
   logic [ROW_WIDTH-1:0]     row_sel;
   logic [GLYPH_ROWS-1:0]    col_bits;
   cell_mask_type            cells_next;
   logic                     cur_last;
   logic                     emit;

   logic [X_WIDTH:0]         left_sum, right_sum;
   logic [Y_WIDTH:0]         top_sum, bottom_sum;
   logic [X_WIDTH:0]         left_wrap, right_wrap;
   logic [Y_WIDTH:0]         top_wrap, bottom_wrap;

   // Lowest non-empty column, then the lowest lit row inside it.
   always_comb begin
      col_sel = '0;
      for (int c = GLYPH_COLS - 1; c >= 0; c--) begin
         if (|cur_cells_ff[c]) begin
            col_sel = COL_WIDTH'(c);
         end
      end
   end

   assign col_bits = cur_cells_ff[col_sel];

   always_comb begin
      row_sel = '0;
      for (int r = GLYPH_ROWS - 1; r >= 0; r--) begin
         if (col_bits[r]) begin
            row_sel = ROW_WIDTH'(r);
         end
      end
   end

   always_comb begin
      cells_next                   = cur_cells_ff;
      cells_next[col_sel][row_sel] = 1'b0;
   end

   assign cur_last = (cells_next == '0);
   assign emit     = cur_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop      = !q_status.empty && (!cur_valid_ff || (emit && cur_last));

   // Block corners; each sum stays below twice the screen size.
   always_comb begin
      left_sum    = (X_WIDTH+1)'(cur_x_ff) + (X_WIDTH+1)'({col_sel, 1'b0}) + (X_WIDTH+1)'(2);
      right_sum   = left_sum + 1'b1;
      top_sum     = (Y_WIDTH+1)'(cur_y_ff) + (Y_WIDTH+1)'({row_sel, 1'b0});
      bottom_sum  = top_sum + 1'b1;
      left_wrap   = (left_sum >= (X_WIDTH+1)'(SCREEN_WIDTH)) ?
                    left_sum - (X_WIDTH+1)'(SCREEN_WIDTH) : left_sum;
      right_wrap  = (right_sum >= (X_WIDTH+1)'(SCREEN_WIDTH)) ?
                    right_sum - (X_WIDTH+1)'(SCREEN_WIDTH) : right_sum;
      top_wrap    = (top_sum >= (Y_WIDTH+1)'(SCREEN_HEIGHT)) ?
                    top_sum - (Y_WIDTH+1)'(SCREEN_HEIGHT) : top_sum;
      bottom_wrap = (bottom_sum >= (Y_WIDTH+1)'(SCREEN_HEIGHT)) ?
                    bottom_sum - (Y_WIDTH+1)'(SCREEN_HEIGHT) : bottom_sum;
   end

   // Current glyph: load from the queue, or clear the cell just emitted.
   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_cells_in = cur_cells_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         cur_cells_in = q_data.cells;
      end else if (emit) begin
         cur_valid_in = !cur_last;
         cur_cells_in = cells_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_cells_ff <= cur_cells_in;
      if (pop) begin
         cur_x_ff <= q_data.x0;
         cur_y_ff <= q_data.y0;
      end
   end

   // Output register.
   always_comb begin
      rsp_data_in.left_x      = OUT_X_WIDTH'(left_wrap);
      rsp_data_in.right_x     = OUT_X_WIDTH'(right_wrap);
      rsp_data_in.top_y       = OUT_Y_WIDTH'(top_wrap);
      rsp_data_in.bottom_y    = OUT_Y_WIDTH'(bottom_wrap);
      rsp_data_in.pixel_color = fore_color;
      rsp_data_in.last_block  = cur_last;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/fgbr_checker.sv
// Port-level checks of the glyph renderer and their attachment to the top level.
`default_nettype none

module fgbr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input fgbr_pkg::req_type                   req_data,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input fgbr_pkg::rsp_type                   rsp_data
);
   import fgbr_pkg::*;

   // A character word that is not taken holds still.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("character word changed while stalled");

   // A result word that is not taken holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // Reset leaves no result word pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The right column sits one pixel right of the left one, wrapping to zero.
   a_x_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.left_x == OUT_X_WIDTH'(SCREEN_WIDTH - 1)) ?
                     (rsp_data.right_x == '0) :
                     (rsp_data.right_x == rsp_data.left_x + 1'b1)))
      else $error("block columns are not adjacent");

   // The lower row sits one pixel below the upper one, wrapping to zero.
   a_y_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.top_y == OUT_Y_WIDTH'(SCREEN_HEIGHT - 1)) ?
                     (rsp_data.bottom_y == '0) :
                     (rsp_data.bottom_y == rsp_data.top_y + 1'b1)))
      else $error("block rows are not adjacent");

endmodule

bind font_glyph_block_renderer fgbr_checker u_checker (.*);

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench of the 5x7 font glyph block renderer.
`timescale 1ns / 100ps

module tb_top;
   import fgbr_pkg::*;

   localparam int RESET_CYCLES  = 11;
   localparam int IDLE_PERCENT  = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int RUN_LIMIT_NS  = 2000000;
   localparam logic [COLOR_WIDTH-1:0] BLACK = 24'h000000;
   localparam logic [COLOR_WIDTH-1:0] WHITE = 24'hFFFFFF;
   localparam logic [CODE_WIDTH-1:0]  CODE_NEWLINE = 8'd10;
   localparam logic [CODE_WIDTH-1:0]  CODE_SPACE   = 8'd32;
   localparam logic [CODE_WIDTH-1:0]  CODE_EXCLAIM = 8'd33;
   localparam logic [CODE_WIDTH-1:0]  CODE_LAST    = 8'd125;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [COLOR_WIDTH-1:0] csr_data = '0;

   // Characters waiting to be sent and pixel blocks waiting to be seen.
   req_type                char_q[$];
   rsp_type                block_q[$];
   logic [COLOR_WIDTH-1:0] color_model = COLOR_RESET;

   logic quiet_mode = 1'b0;
   logic hold_armed = 1'b0;
   int   hold_count = 0;
   int   error_count = 0;
   int   chars_accepted = 0;
   int   blocks_checked = 0;
   int   color_writes = 0;

   font_glyph_block_renderer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Free-running clock, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Column bytes of each printable glyph, column 0 in the top byte.
   function automatic logic [39:0] font_columns(input logic [CODE_WIDTH-1:0] code);
      logic [39:0] cols;
      case (code)
         8'd33:  cols = 40'h00005F0000;
         8'd34:  cols = 40'h0007000700;
         8'd35:  cols = 40'h147F147F14;
         8'd36:  cols = 40'h242A7F2A12;
         8'd37:  cols = 40'h2313086462;
         8'd38:  cols = 40'h3649552250;
         8'd39:  cols = 40'h0005030000;
         8'd40:  cols = 40'h001C224100;
         8'd41:  cols = 40'h0041221C00;
         8'd42:  cols = 40'h082A1C2A08;
         8'd43:  cols = 40'h08083E0808;
         8'd44:  cols = 40'h0050300000;
         8'd45:  cols = 40'h0808080808;
         8'd46:  cols = 40'h0060600000;
         8'd47:  cols = 40'h2010080402;
         8'd48:  cols = 40'h3E5149453E;
         8'd49:  cols = 40'h00427F4000;
         8'd50:  cols = 40'h4261514946;
         8'd51:  cols = 40'h2141454B31;
         8'd52:  cols = 40'h1814127F10;
         8'd53:  cols = 40'h2745454539;
         8'd54:  cols = 40'h3C4A494930;
         8'd55:  cols = 40'h0171090503;
         8'd56:  cols = 40'h3649494936;
         8'd57:  cols = 40'h064949291E;
         8'd58:  cols = 40'h0036360000;
         8'd59:  cols = 40'h0056360000;
         8'd60:  cols = 40'h0008142241;
         8'd61:  cols = 40'h1414141414;
         8'd62:  cols = 40'h4122140800;
         8'd63:  cols = 40'h0201510906;
         8'd64:  cols = 40'h324979413E;
         8'd65:  cols = 40'h7E1111117E;
         8'd66:  cols = 40'h7F49494936;
         8'd67:  cols = 40'h3E41414122;
         8'd68:  cols = 40'h7F4141221C;
         8'd69:  cols = 40'h7F49494941;
         8'd70:  cols = 40'h7F09090101;
         8'd71:  cols = 40'h3E41415132;
         8'd72:  cols = 40'h7F0808087F;
         8'd73:  cols = 40'h00417F4100;
         8'd74:  cols = 40'h2040413F01;
         8'd75:  cols = 40'h7F08142241;
         8'd76:  cols = 40'h7F40404040;
         8'd77:  cols = 40'h7F0204027F;
         8'd78:  cols = 40'h7F0408107F;
         8'd79:  cols = 40'h3E4141413E;
         8'd80:  cols = 40'h7F09090906;
         8'd81:  cols = 40'h3E4151215E;
         8'd82:  cols = 40'h7F09192946;
         8'd83:  cols = 40'h4649494931;
         8'd84:  cols = 40'h01017F0101;
         8'd85:  cols = 40'h3F4040403F;
         8'd86:  cols = 40'h1F2040201F;
         8'd87:  cols = 40'h7F2018207F;
         8'd88:  cols = 40'h6314081463;
         8'd89:  cols = 40'h0304780403;
         8'd90:  cols = 40'h6151494543;
         8'd91:  cols = 40'h00007F4141;
         8'd92:  cols = 40'h0204081020;
         8'd93:  cols = 40'h41417F0000;
         8'd94:  cols = 40'h0402010204;
         8'd95:  cols = 40'h4040404040;
         8'd96:  cols = 40'h0001020400;
         8'd97:  cols = 40'h2054545478;
         8'd98:  cols = 40'h7F48444438;
         8'd99:  cols = 40'h3844444420;
         8'd100: cols = 40'h384444487F;
         8'd101: cols = 40'h3854545418;
         8'd102: cols = 40'h087E090102;
         8'd103: cols = 40'h081454543C;
         8'd104: cols = 40'h7F08040478;
         8'd105: cols = 40'h00447D4000;
         8'd106: cols = 40'h2040443D00;
         8'd107: cols = 40'h007F102844;
         8'd108: cols = 40'h00417F4000;
         8'd109: cols = 40'h7C04180478;
         8'd110: cols = 40'h7C08040478;
         8'd111: cols = 40'h3844444438;
         8'd112: cols = 40'h7C14141408;
         8'd113: cols = 40'h081414187C;
         8'd114: cols = 40'h7C08040408;
         8'd115: cols = 40'h4854545420;
         8'd116: cols = 40'h043F444020;
         8'd117: cols = 40'h3C4040207C;
         8'd118: cols = 40'h1C2040201C;
         8'd119: cols = 40'h3C4030403C;
         8'd120: cols = 40'h4428102844;
         8'd121: cols = 40'h0C5050503C;
         8'd122: cols = 40'h4464544C44;
         8'd123: cols = 40'h0008364100;
         8'd124: cols = 40'h00007F0000;
         8'd125: cols = 40'h0041360800;
         // Space and every code outside the printable range draw nothing.
         default: cols = '0;
      endcase
      return cols;
   endfunction

   // Modulo that never goes negative.
   function automatic int wrap_coord(input int value, input int size);
      int r;
      r = value % size;
      if (r < 0) begin
         r += size;
      end
      return r;
   endfunction

   // Queue the pixel blocks one character is expected to produce.
   task automatic predict_blocks(input req_type item);
      logic [39:0] cols;
      logic [7:0]  col_bits;
      int          x0;
      int          y0;
      int          lit;
      rsp_type     blk;
      lit = 0;
      if (item.char_code != CODE_NEWLINE) begin
         cols = font_columns(item.char_code);
         x0 = wrap_coord(int'($signed(item.pos_x)), SCREEN_WIDTH) + 2;
         y0 = wrap_coord(int'($signed(item.pos_y)), SCREEN_HEIGHT);
         for (int c = 0; c < GLYPH_COLS; c++) begin
            col_bits = cols[39 - 8 * c -: 8];
            for (int r = 0; r < GLYPH_ROWS; r++) begin
               if (col_bits[r]) begin
                  blk.left_x      = OUT_X_WIDTH'(wrap_coord(x0 + 2 * c, SCREEN_WIDTH));
                  blk.right_x     = OUT_X_WIDTH'(wrap_coord(x0 + 2 * c + 1, SCREEN_WIDTH));
                  blk.top_y       = OUT_Y_WIDTH'(wrap_coord(y0 + 2 * r, SCREEN_HEIGHT));
                  blk.bottom_y    = OUT_Y_WIDTH'(wrap_coord(y0 + 2 * r + 1, SCREEN_HEIGHT));
                  blk.pixel_color = color_model;
                  blk.last_block  = 1'b0;
                  block_q.push_back(blk);
                  lit++;
               end
            end
         end
         if (lit > 0) begin
            block_q[block_q.size() - 1].last_block = 1'b1;
         end
      end
   endtask

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected,
                  actual);
         error_count++;
      end
   endtask

   // Driver: predicts on every accepted word and offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_blocks(req_data);
            chars_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (char_q.size() > 0 && (quiet_mode || $urandom_range(99) >= IDLE_PERCENT)) begin
               req_data  <= char_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Counts the cycles of the long receiver hold-off once it is armed.
   always @(posedge clock) begin
      if (hold_armed && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
      end
   end

   // Monitor: compares each result word with the oldest expected block.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (block_q.size() == 0) begin
               $display("%0t: unexpected block, expected none, actual %h", $time, rsp_data);
               error_count++;
            end else begin
               want = block_q.pop_front();
               check_field("left_x", want.left_x, rsp_data.left_x);
               check_field("right_x", want.right_x, rsp_data.right_x);
               check_field("top_y", want.top_y, rsp_data.top_y);
               check_field("bottom_y", want.bottom_y, rsp_data.bottom_y);
               check_field("pixel_color", want.pixel_color, rsp_data.pixel_color);
               check_field("last_block", want.last_block, rsp_data.last_block);
            end
            blocks_checked++;
         end
         // A long hold-off once armed, otherwise random back-pressure.
         if (hold_armed && hold_count < HOLD_CYCLES) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   task automatic add_char(input int x, input int y, input int code);
      req_type item;
      item.pos_x     = x[POS_WIDTH-1:0];
      item.pos_y     = y[POS_WIDTH-1:0];
      item.char_code = code[CODE_WIDTH-1:0];
      char_q.push_back(item);
   endtask

   // Mostly drawable characters; the rest are newlines, spaces and
   // codes outside the printable range. Only drawable ones count.
   task automatic add_random_chars(input int drawable);
      int      made;
      int      pick;
      req_type item;
      made = 0;
      while (made < drawable) begin
         pick = $urandom_range(99);
         item.pos_x = POS_WIDTH'($urandom_range(4095));
         item.pos_y = POS_WIDTH'($urandom_range(4095));
         if (pick < 80) begin
            item.char_code = CODE_WIDTH'($urandom_range(CODE_LAST, CODE_EXCLAIM));
            made++;
         end else if (pick < 85) begin
            item.char_code = CODE_NEWLINE;
         end else if (pick < 90) begin
            item.char_code = CODE_WIDTH'($urandom_range(31, 0));
         end else if (pick < 95) begin
            item.char_code = CODE_WIDTH'($urandom_range(255, 126));
         end else begin
            item.char_code = CODE_SPACE;
         end
         char_q.push_back(item);
      end
   endtask

   // Sampled at the falling edge so the queues and valids are settled.
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (char_q.size() != 0 || req_valid || block_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_color(input logic [COLOR_WIDTH-1:0] value);
      @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid   <= 1'b0;
      color_model = value;
      color_writes++;
   endtask

   // Stimulus sequence.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed characters at the reset color.
      add_char(0, 0, 65);
      add_char(-2048, -2048, 35);
      add_char(2047, 2047, 87);
      add_char(309, 227, 77);       // right and bottom edges wrap to zero
      add_char(310, 228, 72);       // left and top edges wrap to zero
      add_char(-1, -1, 56);
      add_char(319, 239, 64);
      add_char(0, 0, 10);           // newline
      add_char(5, 5, 0);            // control codes print as space
      add_char(5, 5, 31);
      add_char(5, 5, 32);
      add_char(7, 9, 33);           // first and last printable codes
      add_char(100, 100, 125);
      add_char(100, 100, 126);      // above the printable range
      add_char(100, 100, 255);
      add_char(-320, -240, 66);
      add_char(-321, -241, 103);
      add_char(2047, -2048, 95);
      add_char(-2048, 2047, 124);
      add_char(12'h555, 12'hAAA, 8'h55);
      add_char(12'hAAA, 12'h555, 8'hAA);
      wait_drained();

      // Black with random idling on both sides.
      write_color(BLACK);
      add_random_chars(16);
      wait_drained();

      // Random color while the receiver holds off and the queue fills.
      write_color(COLOR_WIDTH'($urandom));
      hold_armed = 1'b1;
      add_random_chars(16);
      wait_drained();

      // White with no idling at all.
      write_color(WHITE);
      quiet_mode = 1'b1;
      add_random_chars(18);
      wait_drained();
      quiet_mode = 1'b0;

      // Mixed bit pattern, random idling again.
      write_color(24'h5AA5C3);
      add_random_chars(13);
      wait_drained();

      $display("Covered %0d characters and %0d pixel blocks over %0d color writes,",
               chars_accepted, blocks_checked, color_writes);
      $display("including wrapping edges, unprintable codes and a long output stall.");
      if (error_count == 0 && block_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Run limit reached with %0d blocks still expected.", block_q.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
